### src/dzr_pkg.sv
// Shared types and constants for the delta / zero-run frame byte encoder.
`timescale 1ns / 1ps

package dzr_pkg;

  localparam logic [7:0] MAX_RUN  = 8'd255;
  localparam logic [7:0] RUN_MARK = 8'h00;
  localparam logic [7:0] ESCAPE   = 8'hFF;
  localparam int         MAX_STEP = 127;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte burst for one request, compacted: bytes[0..last_idx] are sent in order.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            frame_last;
  } burst_t;

endpackage

### src/dzr_front.sv
// Front end: accepts cells, keeps the run counter and builds byte bursts.
`timescale 1ns / 1ps

module dzr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  input  logic [7:0]      cur_value,
  input  logic [7:0]      prev_value,
  input  logic            frame_last,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output dzr_pkg::burst_t push_burst
);

  logic       delta_mode_r;
  logic [7:0] run_count_r;
  logic [7:0] run_count_nxt;

  logic       match;
  logic [7:0] run_inc;
  logic       flush;
  logic [7:0] run_len;
  logic [1:0] n_data;
  logic [7:0] d0;
  logic [7:0] d1;
  logic       emit;
  logic       accept;

  logic signed [8:0] diff;
  logic signed [8:0] neg_diff;
  logic              small_step;
  logic [7:0]        zig;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign diff       = $signed({1'b0, cur_value}) - $signed({1'b0, prev_value});
  assign neg_diff   = -diff;
  assign small_step = (diff >= -9'sd127) && (diff <= 9'sd127);
  assign zig        = diff[8] ? {neg_diff[6:0], 1'b0} : ({diff[6:0], 1'b0} - 8'd1);

  assign match   = delta_mode_r ? (cur_value == prev_value) : (cur_value == 8'd0);
  assign run_inc = run_count_r + 8'd1;

  always_comb begin
    d0 = cur_value;
    d1 = cur_value;
    if (match) begin
      flush   = (run_inc >= dzr_pkg::MAX_RUN) || frame_last;
      run_len = run_inc;
      n_data  = 2'd0;
      emit    = flush;
    end else begin
      flush   = (run_count_r != 8'd0);
      run_len = run_count_r;
      emit    = 1'b1;
      if (!delta_mode_r) begin
        n_data = 2'd1;
      end else if (small_step) begin
        n_data = 2'd1;
        d0     = zig;
      end else begin
        n_data = 2'd2;
        d0     = dzr_pkg::ESCAPE;
      end
    end
  end

  always_comb begin
    push_burst.frame_last = frame_last;
    push_burst.bytes[0]   = d0;
    push_burst.bytes[1]   = d1;
    push_burst.bytes[2]   = d0;
    push_burst.bytes[3]   = d1;
    if (flush) begin
      push_burst.bytes[0] = dzr_pkg::RUN_MARK;
      push_burst.bytes[1] = run_len;
      push_burst.last_idx = n_data + 2'd1;
    end else begin
      push_burst.last_idx = n_data - 2'd1;
    end
  end

  assign push = accept && emit;

  always_comb begin
    run_count_nxt = run_count_r;
    if (accept) begin
      run_count_nxt = (match && !flush) ? run_inc : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_mode_r <= 1'b1;
      run_count_r  <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        delta_mode_r <= cfg_wr_data;
      end
      run_count_r <= run_count_nxt;
    end
  end

endmodule

### src/dzr_queue.sv
// Short burst queue between front end and serialiser.
`timescale 1ns / 1ps

module dzr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dzr_pkg::burst_t push_burst,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output dzr_pkg::burst_t head
);

  dzr_pkg::burst_t                entry_r [dzr_pkg::QUEUE_DEPTH];
  logic [dzr_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [dzr_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [dzr_pkg::QCNT_W-1:0]     count_r;
  logic [dzr_pkg::QCNT_W-1:0]     count_nxt;

  assign full  = (count_r == dzr_pkg::QCNT_W'(dzr_pkg::QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_burst;
    end
  end

endmodule

### src/dzr_back.sv
// Back end: serialises queued bursts into the registered byte stream.
`timescale 1ns / 1ps

module dzr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  dzr_pkg::burst_t q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            item_last,
  output logic            frame_end
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       item_last_r;
  logic       frame_end_r;
  logic [1:0] idx_r;
  logic       load;
  logic       is_last;

  assign load    = !out_valid_r || out_ready;
  assign is_last = (idx_r == q_head.last_idx);
  assign pop     = load && q_valid && is_last;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign item_last = item_last_r;
  assign frame_end = frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= q_valid;
      if (q_valid) begin
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_byte_r  <= q_head.bytes[idx_r];
      item_last_r <= is_last;
      frame_end_r <= is_last && q_head.frame_last;
    end
  end

endmodule

### src/delta_zigzag_run_frame_encoder.sv
// Delta / zero-run frame byte encoder: top level.
// Usage:
//   in_*  : one cell per request. in_tdata = {prev_value, cur_value}, cur_value in
//           bits 7:0; in_tlast marks the frame's last cell.
//   out_* : one coded byte per request. out_tuser flags the last byte caused by
//           a cell, out_tlast flags the final byte of the coded frame.
//   cfg_* : cfg_wr_en writes cfg_wr_data into delta_mode (1 = delta coding,
//           0 = keyframe coding). Write only while the block is idle.
// Timing: a cell is accepted every cycle while the two-entry burst queue has
//   room; the first byte it causes passes through the queue entry and the
//   output register before it appears on out_*. The serialiser sends one byte
//   per cycle while out_tready allows it; a cell causes 0 to 4 bytes: one for a
//   zigzag byte or literal, two for an escape, two more when a run is flushed.
//   Cells that only extend a run cost nothing at the output.
// Reset: delta_mode is set, the run counter and queue are emptied, no byte
//   is pending. No clearing pass.
// Stall: with out_tready low the output byte holds, the queue fills and
//   in_tready drops; no byte is lost or repeated.
`timescale 1ns / 1ps

module delta_zigzag_run_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] cur_value, [15:8] prev_value
  input  logic        in_tlast,   // frame_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] item_last
  output logic        out_tlast   // frame_end
);

  logic            q_full;
  logic            q_valid;
  logic            push;
  logic            pop;
  dzr_pkg::burst_t push_burst;
  dzr_pkg::burst_t q_head;

  dzr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .cur_value  (in_tdata[7:0]),
    .prev_value (in_tdata[15:8]),
    .frame_last (in_tlast),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_burst (push_burst)
  );

  dzr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_burst(push_burst),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  dzr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (out_tdata),
    .item_last(out_tuser),
    .frame_end(out_tlast)
  );

endmodule

### sim/delta_zigzag_run_frame_encoder_tb.sv
// Self-checking testbench for the delta / zero-run frame byte encoder.
`timescale 1ns / 1ps

module delta_zigzag_run_frame_encoder_tb;

  localparam int RANDOM_CELLS = 385;
  localparam int SETTLE       = 10;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [7:0] data;
    logic       item_last;
    logic       frame_end;
  } coded_byte_t;

  // n_typed < 0: bytes come from the predictor
  typedef struct {
    bit          is_mode;
    logic [7:0]  cur;
    logic [7:0]  prev;
    logic        last;
    int          n_typed;
    logic [31:0] typed;
  } stim_row_t;

  typedef enum {CELL_MATCH, CELL_STEP, CELL_EDGE, CELL_JUMP, CELL_NOISE} cell_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic        delta_on;
  logic [7:0]  pend_run;
  logic [7:0]  cell_bytes[$];
  coded_byte_t coded_due[$];
  stim_row_t   dir_rows[$];
  coded_byte_t want;
  int          mismatches = 0;
  int          cycles = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  delta_zigzag_run_frame_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    cell_bytes = {cell_bytes, b};
  endfunction

  function automatic void flush_run();
    if (pend_run != 8'd0) begin
      add_byte(dzr_pkg::RUN_MARK);
      add_byte(pend_run);
      pend_run = 8'd0;
    end
  endfunction

  // Bytes one cell produces; advances the run counter
  function automatic void code_cell(input logic [7:0] cur, input logic [7:0] prev,
                                    input logic last);
    int d;
    cell_bytes.delete();
    if (delta_on ? (cur == prev) : (cur == 8'd0)) begin
      pend_run = pend_run + 8'd1;
      if (pend_run >= dzr_pkg::MAX_RUN || last) flush_run();
    end else begin
      flush_run();
      if (!delta_on) begin
        add_byte(cur);
      end else begin
        d = int'(cur) - int'(prev);
        if (d >= -dzr_pkg::MAX_STEP && d <= dzr_pkg::MAX_STEP)
          add_byte((d > 0) ? 8'(2 * d - 1) : 8'(-2 * d));
        else begin
          add_byte(dzr_pkg::ESCAPE);
          add_byte(cur);
        end
      end
    end
  endfunction

  function automatic void add_cell(input logic [7:0] cur, input logic [7:0] prev,
                                   input logic last, input int n, input logic [31:0] b);
    stim_row_t r;
    r.is_mode = 1'b0;
    r.cur     = cur;
    r.prev    = prev;
    r.last    = last;
    r.n_typed = n;
    r.typed   = b;
    dir_rows  = {dir_rows, r};
  endfunction

  function automatic void add_mode(input logic m);
    stim_row_t r;
    r.is_mode = 1'b1;
    r.cur     = {7'd0, m};
    r.prev    = '0;
    r.last    = 1'b0;
    r.n_typed = 0;
    r.typed   = '0;
    dir_rows  = {dir_rows, r};
  endfunction

  // Called at a falling edge; returns at a falling edge
  task automatic send_cell(input logic [7:0] cur, input logic [7:0] prev, input logic last,
                           input int n_typed, input logic [31:0] typed);
    int gap;
    coded_byte_t cb;
    code_cell(cur, prev, last);
    if (n_typed >= 0) begin
      cell_bytes.delete();
      for (int k = 0; k < n_typed; k++)
        add_byte(typed[8 * (n_typed - 1 - k) +: 8]);
    end
    foreach (cell_bytes[i]) begin
      cb.data      = cell_bytes[i];
      cb.item_last = (i == cell_bytes.size() - 1);
      cb.frame_end = last && (i == cell_bytes.size() - 1);
      coded_due    = {coded_due, cb};
    end
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {prev, cur};
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Mode writes only once the block has drained
  task automatic write_mode(input logic m);
    in_tvalid = 1'b0;
    while (coded_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = m;
    delta_on    = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int stall;
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (coded_due.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %02h", $time, out_tdata);
        mismatches++;
      end else begin
        want = coded_due.pop_front();
        if (out_tdata !== want.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want.item_last) begin
          $display("%0t: item_last expected %0b got %0b", $time, want.item_last, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.frame_end) begin
          $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end, out_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int         sent;
    int         frame_len;
    int         run_left;
    int         step;
    int         p;
    int         c;
    bit         first;
    cell_kind_t kind;

    delta_on = 1'b1;
    pend_run = 8'd0;

    // delta mode after reset
    add_cell(8'd5,   8'd5,   1'b0, 0, 32'h0);
    add_cell(8'd5,   8'd5,   1'b1, 2, 32'h0002);
    add_cell(8'd10,  8'd9,   1'b0, 1, 32'h01);
    add_cell(8'd9,   8'd10,  1'b0, 1, 32'h02);
    add_cell(8'd127, 8'd0,   1'b0, 1, 32'hFD);
    add_cell(8'd0,   8'd127, 1'b0, 1, 32'hFE);
    add_cell(8'd128, 8'd0,   1'b0, 2, 32'hFF80);
    add_cell(8'd0,   8'd255, 1'b0, 2, 32'hFF00);
    add_cell(8'd255, 8'd0,   1'b1, 2, 32'hFFFF);
    // run left open across the switch to keyframe coding
    add_cell(8'd3,   8'd3,   1'b0, 0, 32'h0);
    add_mode(1'b0);
    add_cell(8'd0,   8'd77,  1'b0, 0, 32'h0);
    add_cell(8'd0,   8'd0,   1'b1, 2, 32'h0003);
    add_cell(8'd200, 8'd0,   1'b0, 1, 32'hC8);
    add_cell(8'd255, 8'd0,   1'b0, 1, 32'hFF);
    add_cell(8'd7,   8'd7,   1'b0, 1, 32'h07);
    add_cell(8'd0,   8'd9,   1'b0, 0, 32'h0);
    add_cell(8'd1,   8'd0,   1'b1, 3, 32'h000101);
    add_cell(8'd0,   8'd0,   1'b1, 2, 32'h0001);
    add_cell(8'd0,   8'd5,   1'b0, 0, 32'h0);
    add_mode(1'b1);
    add_cell(8'd4,   8'd4,   1'b0, 0, 32'h0);
    add_cell(8'd200, 8'd0,   1'b1, 4, 32'h0002FFC8);
    add_cell(8'h55,  8'hAA,  1'b0, -1, 32'h0);
    add_cell(8'hAA,  8'h55,  1'b1, -1, 32'h0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_mode)
        write_mode(dir_rows[i].cur[0]);
      else
        send_cell(dir_rows[i].cur, dir_rows[i].prev, dir_rows[i].last,
                  dir_rows[i].n_typed, dir_rows[i].typed);
    end

    // frames of runs with random content; first frame carries a run past full length
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_CELLS) begin
      frame_len = first ? 262 : $urandom_range(1, 24);
      run_left  = first ? 256 : 0;
      if (!first && $urandom_range(0, 2) == 0) write_mode(1'($urandom_range(0, 1)));
      first = 1'b0;
      for (int k = 0; k < frame_len; k++) begin
        if (k > 0 && $urandom_range(0, 39) == 0) write_mode(1'($urandom_range(0, 1)));
        if (run_left > 0) begin
          kind = CELL_MATCH;
          run_left--;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              kind     = CELL_MATCH;
              run_left = $urandom_range(0, 6);
            end
            5, 6:    kind = CELL_STEP;
            7:       kind = CELL_JUMP;
            8:       kind = CELL_EDGE;
            default: kind = CELL_NOISE;
          endcase
        end
        p = $urandom_range(0, 255);
        case (kind)
          CELL_MATCH: c = delta_on ? p : 0;
          CELL_STEP, CELL_EDGE: begin
            if (kind == CELL_EDGE)
              step = $urandom_range(0, 1) ? dzr_pkg::MAX_STEP : dzr_pkg::MAX_STEP + 1;
            else
              step = $urandom_range(1, dzr_pkg::MAX_STEP);
            if (p + step > 255 || ($urandom_range(0, 1) == 1 && p >= step))
              c = p - step;
            else
              c = p + step;
          end
          CELL_JUMP: c = (p < 128) ? $urandom_range(p + 128, 255) : $urandom_range(0, p - 128);
          default:   c = $urandom_range(0, 255);
        endcase
        send_cell(8'(c), 8'(p), k == frame_len - 1, -1, 32'h0);
        sent++;
      end
    end

    in_tvalid = 1'b0;
    while (coded_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
